@@ rtl/ccfu_pkg.sv @@
// ----------------------------------------------------------------------------
// ccfu_pkg
// Shared types, codes and helpers of the compare and control flow unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfu_pkg;

  // Defaults of the top-level parameters
  localparam int MemoryBytesDef = 65536;
  localparam int StackBaseDef   = 61440;
  localparam int StackWordsDef  = 256;

  // Fixed properties
  localparam int InstrBytes = 2;
  localparam int SpW        = 17;  // stack end may pass 16 bits
  localparam int QueueDepth = 2;

  // Operation codes, valued as the incoming mode field
  typedef enum logic [2:0] {
    OP_CMP  = 3'd0,
    OP_JMP  = 3'd1,
    OP_JZ   = 3'd2,
    OP_JNZ  = 3'd3,
    OP_CALL = 3'd4,
    OP_RET  = 3'd5,
    OP_NOP  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_BOUNDS = 2'd1,
    FAULT_ALIGN  = 2'd2,
    FAULT_STACK  = 2'd3
  } fault_e;

  typedef struct packed {
    logic v;
    logic c;
    logic n;
    logic z;
  } flags_t;

  // Classified word handed from front to back
  typedef struct packed {
    op_e         op;
    logic [15:0] pc;
    logic [15:0] target;
    fault_e      tfault;
    flags_t      flags;
  } entry_t;

  // Bounds check first, then alignment
  function automatic fault_e check_target(input logic [15:0] addr,
                                          input logic [16:0] limit);
    fault_e f;
    if ({1'b0, addr} > limit) begin
      f = FAULT_BOUNDS;
    end else if (addr[0]) begin
      f = FAULT_ALIGN;
    end else begin
      f = FAULT_NONE;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

@@ rtl/compare_and_control_flow_unit_core.sv @@
// ----------------------------------------------------------------------------
// compare_and_control_flow_unit_core
// Path: an accepted word is written into the queue, then into the result reg.
// Throughput: 1 word per cycle while the output is not stalled; the back end retires one queued word a cycle.
// Output stalls back up through the 2-entry queue before input tready drops.
// Reset: flags clear, stack pointer at stack end, queue and result empty.
// ----------------------------------------------------------------------------
`default_nettype none

module compare_and_control_flow_unit_core #(
  parameter int MEMORY_BYTES = ccfu_pkg::MemoryBytesDef,
  parameter int STACK_BASE   = ccfu_pkg::StackBaseDef,
  parameter int STACK_WORDS  = ccfu_pkg::StackWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] mode, [3] use_immediate
  input  logic [3:0]  s_axis_tuser_i,
  // [15:0] pc, [26:16] branch_offset, [42:27] first_value,
  // [58:43] second_value, [74:59] immediate_value, [79:75] zero
  input  logic [79:0] s_axis_tdata_i,
  // Result words
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] next_pc, [16] pc_written, [18:17] fault_code,
  // [34:19] fault_address, [35] halted, [36] zero_flag,
  // [37] negative_flag, [38] carry_flag, [39] overflow_flag
  output logic [39:0] m_axis_tdata_o
);
  import ccfu_pkg::*;

  entry_t      front_entry;
  entry_t      head_entry;
  logic        queue_full;
  logic        head_valid;
  logic        head_pop;
  logic        in_fire;

  logic [15:0] next_pc;
  logic        pc_written;
  logic [1:0]  fault_code;
  logic [15:0] fault_address;
  logic        halted;
  flags_t      flags;

  // Input side: only the queue level gates acceptance
  assign s_axis_tready_o = ~queue_full;
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  // Front end: decode, target and its fault, compare flags
  ccfu_front #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_front (
    .mode_i            (s_axis_tuser_i[2:0]),
    .use_immediate_i   (s_axis_tuser_i[3]),
    .pc_i              (s_axis_tdata_i[15:0]),
    .branch_offset_i   (s_axis_tdata_i[26:16]),
    .first_value_i     (s_axis_tdata_i[42:27]),
    .second_value_i    (s_axis_tdata_i[58:43]),
    .immediate_value_i (s_axis_tdata_i[74:59]),
    .entry_o           (front_entry)
  );

  // Decoupling queue
  ccfu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_fire),
    .push_entry_i (front_entry),
    .full_o       (queue_full),
    .pop_i        (head_pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  // Back end: flag state, return stack, result register
  ccfu_back #(
    .MEMORY_BYTES (MEMORY_BYTES),
    .STACK_BASE   (STACK_BASE),
    .STACK_WORDS  (STACK_WORDS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_entry_i    (head_entry),
    .pop_o           (head_pop),
    .res_valid_o     (m_axis_tvalid_o),
    .res_ready_i     (m_axis_tready_i),
    .next_pc_o       (next_pc),
    .pc_written_o    (pc_written),
    .fault_code_o    (fault_code),
    .fault_address_o (fault_address),
    .halted_o        (halted),
    .flags_o         (flags)
  );

  assign m_axis_tdata_o = {flags.v, flags.c, flags.n, flags.z, halted,
                           fault_address, fault_code, pc_written, next_pc};

endmodule

`default_nettype wire

@@ rtl/ccfu_front.sv @@
// ----------------------------------------------------------------------------
// ccfu_front
// Decodes a word: operation, jump target with its fault, compare flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfu_front #(
  parameter int MEMORY_BYTES = ccfu_pkg::MemoryBytesDef
) (
  input  logic [2:0]           mode_i,
  input  logic                 use_immediate_i,
  input  logic [15:0]          pc_i,
  input  logic signed [10:0]   branch_offset_i,
  input  logic [15:0]          first_value_i,
  input  logic [15:0]          second_value_i,
  input  logic [15:0]          immediate_value_i,
  output ccfu_pkg::entry_t     entry_o
);
  import ccfu_pkg::*;

  localparam logic [16:0] TargetLimit = 17'(MEMORY_BYTES - InstrBytes);

  logic [15:0] offset_ext;
  logic [15:0] target;
  logic [15:0] src;
  logic [16:0] diff;
  logic [15:0] res;
  op_e         op;

  always_comb begin
    case (mode_i)
      OP_CMP:  op = OP_CMP;
      OP_JMP:  op = OP_JMP;
      OP_JZ:   op = OP_JZ;
      OP_JNZ:  op = OP_JNZ;
      OP_CALL: op = OP_CALL;
      OP_RET:  op = OP_RET;
      default: op = OP_NOP;
    endcase
  end

  assign offset_ext = {{5{branch_offset_i[10]}}, branch_offset_i};
  assign target     = use_immediate_i ? (pc_i + offset_ext) : second_value_i;

  // 16-bit subtract; bit 16 is the borrow
  assign src  = use_immediate_i ? immediate_value_i : second_value_i;
  assign diff = {1'b0, first_value_i} - {1'b0, src};
  assign res  = diff[15:0];

  always_comb begin
    entry_o.op      = op;
    entry_o.pc      = pc_i;
    entry_o.target  = target;
    entry_o.tfault  = check_target(target, TargetLimit);
    entry_o.flags.z = (res == 16'd0);
    entry_o.flags.n = res[15];
    entry_o.flags.c = diff[16];
    entry_o.flags.v = (first_value_i[15] ^ src[15]) & (first_value_i[15] ^ res[15]);
  end

endmodule

`default_nettype wire

@@ rtl/ccfu_queue.sv @@
// ----------------------------------------------------------------------------
// ccfu_queue
// Short FIFO between front and back; full rate with push and pop together.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ccfu_pkg::entry_t  push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output ccfu_pkg::entry_t  head_entry_o
);
  import ccfu_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  entry_t          slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o       = (count_q == CntFull);
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ccfu_back.sv @@
// ----------------------------------------------------------------------------
// ccfu_back
// Executes classified words: flags, taken jumps, return stack, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfu_back #(
  parameter int MEMORY_BYTES = ccfu_pkg::MemoryBytesDef,
  parameter int STACK_BASE   = ccfu_pkg::StackBaseDef,
  parameter int STACK_WORDS  = ccfu_pkg::StackWordsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  ccfu_pkg::entry_t  head_entry_i,
  output logic              pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [15:0]       next_pc_o,
  output logic              pc_written_o,
  output logic [1:0]        fault_code_o,
  output logic [15:0]       fault_address_o,
  output logic              halted_o,
  output ccfu_pkg::flags_t  flags_o
);
  import ccfu_pkg::*;

  localparam int IdxW = $clog2(STACK_WORDS);
  localparam logic [16:0]    TargetLimit = 17'(MEMORY_BYTES - InstrBytes);
  localparam logic [SpW-1:0] SpBase      = SpW'(STACK_BASE);
  localparam logic [SpW-1:0] SpEnd       = SpW'(STACK_BASE + 2 * STACK_WORDS);
  localparam logic [SpW-1:0] SpFull      = SpW'(STACK_BASE + 2);

  // Top entry lives in tos_q, the next one in below_q or the memory read
  // register; the memory keeps every entry under the top.
  logic [15:0]     stack_mem [STACK_WORDS];
  logic [15:0]     rd_q;
  logic [15:0]     tos_q;
  logic [15:0]     below_q;
  logic            below_mem_q;
  logic [15:0]     below;

  logic [SpW-1:0]  sp_q, sp_d;
  flags_t          flags_q, flags_d;
  logic [SpW-1:0]  sp_off;
  logic [IdxW-1:0] top_idx;
  logic [IdxW-1:0] rd_idx;
  logic            empty;

  logic            fire;
  logic            push;
  logic            pop;
  logic            taken;
  fault_e          ret_fault;
  logic [15:0]     nxt_pc;
  logic            written;
  fault_e          fcode;
  logic [15:0]     faddr;
  logic            halt;

  logic            valid_q;

  assign fire  = head_valid_i & (~valid_q | res_ready_i);
  assign pop_o = fire;

  assign sp_off  = sp_q - SpBase;
  assign top_idx = sp_off[IdxW:1];
  assign rd_idx  = top_idx + IdxW'(2);
  assign empty   = (sp_q >= SpEnd);
  assign below   = below_mem_q ? rd_q : below_q;

  assign ret_fault = check_target(tos_q, TargetLimit);

  always_comb begin
    nxt_pc  = head_entry_i.pc;
    written = 1'b0;
    fcode   = FAULT_NONE;
    faddr   = 16'd0;
    halt    = 1'b0;
    flags_d = flags_q;
    push    = 1'b0;
    pop     = 1'b0;
    taken   = 1'b0;
    case (head_entry_i.op)
      OP_CMP: begin
        flags_d = head_entry_i.flags;
      end
      OP_JMP, OP_JZ, OP_JNZ: begin
        taken = (head_entry_i.op == OP_JMP) ||
                ((head_entry_i.op == OP_JZ) && flags_q.z) ||
                ((head_entry_i.op == OP_JNZ) && !flags_q.z);
        if (taken) begin
          if (head_entry_i.tfault != FAULT_NONE) begin
            fcode = head_entry_i.tfault;
            faddr = head_entry_i.target;
          end else begin
            nxt_pc  = head_entry_i.target;
            written = 1'b1;
          end
        end
      end
      OP_CALL: begin
        if (head_entry_i.tfault != FAULT_NONE) begin
          fcode = head_entry_i.tfault;
          faddr = head_entry_i.target;
        end else if (sp_q < SpFull) begin
          fcode = FAULT_STACK;
          faddr = sp_q[15:0];
        end else begin
          push    = 1'b1;
          nxt_pc  = head_entry_i.target;
          written = 1'b1;
        end
      end
      OP_RET: begin
        if (empty) begin
          halt = 1'b1;
        end else begin
          // pop stands even when the popped address faults
          pop = 1'b1;
          if (ret_fault != FAULT_NONE) begin
            fcode = ret_fault;
            faddr = tos_q;
          end else begin
            nxt_pc  = tos_q;
            written = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sp_d = sp_q;
    if (push) begin
      sp_d = sp_q - SpW'(2);
    end else if (pop) begin
      sp_d = sp_q + SpW'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= SpEnd;
      flags_q     <= '0;
      below_mem_q <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      if (fire) begin
        sp_q    <= sp_d;
        flags_q <= flags_d;
        if (push) begin
          below_mem_q <= 1'b0;
        end else if (pop) begin
          below_mem_q <= 1'b1;
        end
      end
      if (fire) begin
        valid_q <= 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (fire && push && !empty) begin
      stack_mem[top_idx] <= tos_q;
    end
    if (fire && pop) begin
      rd_q <= stack_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (push) begin
        tos_q   <= head_entry_i.pc;
        below_q <= tos_q;
      end else if (pop) begin
        tos_q <= below;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      next_pc_o       <= nxt_pc;
      pc_written_o    <= written;
      fault_code_o    <= fcode;
      fault_address_o <= faddr;
      halted_o        <= halt;
      flags_o         <= flags_d;
    end
  end

  assign res_valid_o = valid_q;

endmodule

`default_nettype wire

@@ sim/compare_and_control_flow_unit_core_test.sv @@
// ----------------------------------------------------------------------------
// compare_and_control_flow_unit_core_test
// Self-checking bench for the compare and control flow unit. An initial block
// queues instruction words: a directed opener, one run that fills the return
// stack past its limit and drains it past empty, then random compare/branch
// pairs, nested call/return groups and loose words. A negedge driver offers
// them with random gaps. A posedge monitor predicts each accepted word with
// its own flag and return-stack state and checks every result field in order,
// while the receiver stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------

module compare_and_control_flow_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfu_pkg::*;

  localparam int MemoryBytes = MemoryBytesDef;
  localparam int StackBase   = StackBaseDef;
  localparam int StackWords  = StackWordsDef;
  localparam int StackEnd    = StackBase + 2 * StackWords;
  localparam int TargetLimit = MemoryBytes - InstrBytes;

  localparam logic [2:0] ModeReserved = 3'd7;  // no enum member, acts as no-op

  localparam int TotalWords  = 1950;
  localparam int TailWords   = 200;        // last stretch runs without idling
  localparam int HoldAfter   = 400;        // long output stall starts here
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 10;         // covers queue and result reg, with margin
  localparam int TimeoutNs   = 2_000_000;

  // One instruction word as offered on the input side
  typedef struct packed {
    logic        use_imm;
    logic [2:0]  mode;
    logic [15:0] pc;
    logic [10:0] offset;
    logic [15:0] first_val;
    logic [15:0] second_val;
    logic [15:0] imm_val;
  } instr_word_t;

  // Result word, laid out as m_axis_tdata_o (MSB first)
  typedef struct packed {
    logic        overflow;
    logic        carry;
    logic        negative;
    logic        zero;
    logic        halted;
    logic [15:0] fault_addr;
    fault_e      fault;
    logic        pc_written;
    logic [15:0] next_pc;
  } exec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [3:0]  s_axis_tuser_i = '0;   // [2:0] mode, [3] use_immediate
  // [15:0] pc, [26:16] branch_offset, [42:27] first_value,
  // [58:43] second_value, [74:59] immediate_value, [79:75] zero
  logic [79:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [15:0] next_pc, [16] pc_written, [18:17] fault_code, [34:19] fault_address,
  // [35] halted, [36] zero, [37] negative, [38] carry, [39] overflow
  logic [39:0] m_axis_tdata_o;

  compare_and_control_flow_unit_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // Stimulus and expectations
  instr_word_t  pending_instrs[$];
  exec_result_t predicted_results[$];

  // Predictor state: flags, stack pointer (17 bits, end may pass 16) and stack
  flags_t      model_flags = '0;
  logic [16:0] model_sp = 17'(StackEnd);
  logic [15:0] return_addrs [StackWords];

  // Handshake bookkeeping
  bit word_taken = 1'b0;     // input word accepted at the last rising edge
  int instrs_accepted = 0;
  int results_seen = 0;
  int error_count = 0;
  int input_stall_cycles = 0;
  int redirect_count = 0;
  int halt_count = 0;
  int fault_tally [4] = '{0, 0, 0, 0};

  // Idle control, both sides
  int send_cycle = 0, send_gap = 0, send_idle_pct = 10;
  int recv_cycle = 0, recv_gap = 0, recv_idle_pct = 10;
  int hold_cycles = 0;
  bit hold_done = 1'b0;

  exec_result_t want, got, predicted;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bounds first, then alignment
  function automatic fault_e target_fault(input logic [15:0] addr);
    if (addr > TargetLimit) return FAULT_BOUNDS;
    if (addr[0]) return FAULT_ALIGN;
    return FAULT_NONE;
  endfunction

  // Take the branch, or flag the bad target and leave the pc alone
  function automatic void redirect(input logic [15:0] dest, inout exec_result_t r);
    r.fault = target_fault(dest);
    if (r.fault != FAULT_NONE) begin
      r.fault_addr = dest;
    end else begin
      r.next_pc    = dest;
      r.pc_written = 1'b1;
    end
  endfunction

  function automatic exec_result_t execute_instr(input instr_word_t w);
    exec_result_t r;
    logic [15:0]  target;
    logic [15:0]  src;
    logic [15:0]  diff;
    logic [15:0]  popped;
    logic         taken;
    r = '0;
    r.next_pc = w.pc;
    target = w.use_imm ? w.pc + {{5{w.offset[10]}}, w.offset} : w.second_val;
    taken = (w.mode == OP_JMP) || (w.mode == OP_JZ && model_flags.z) ||
            (w.mode == OP_JNZ && !model_flags.z);
    case (w.mode)
      OP_CMP: begin
        src  = w.use_imm ? w.imm_val : w.second_val;
        diff = w.first_val - src;
        model_flags.z = (diff == 16'h0000);
        model_flags.n = diff[15];
        model_flags.c = (w.first_val < src);   // borrow
        model_flags.v = (w.first_val[15] ^ src[15]) & (w.first_val[15] ^ diff[15]);
      end
      OP_JMP, OP_JZ, OP_JNZ: begin
        if (taken) redirect(target, r);
      end
      OP_CALL: begin
        if (target_fault(target) != FAULT_NONE) begin
          redirect(target, r);
        end else if (model_sp < StackBase + 2) begin
          r.fault      = FAULT_STACK;
          r.fault_addr = model_sp[15:0];
        end else begin
          model_sp -= 17'd2;
          return_addrs[(model_sp - StackBase) >> 1] = w.pc;
          redirect(target, r);
        end
      end
      OP_RET: begin
        if (model_sp >= StackEnd) begin
          r.halted = 1'b1;
        end else begin
          // pop stands even when the popped address faults
          popped = return_addrs[(model_sp - StackBase) >> 1];
          model_sp += 17'd2;
          redirect(popped, r);
        end
      end
      default: ;  // reserved modes change nothing
    endcase
    r.zero     = model_flags.z;
    r.negative = model_flags.n;
    r.carry    = model_flags.c;
    r.overflow = model_flags.v;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic instr_word_t make_word(input logic [2:0] mode, input logic use_imm,
                                            input logic [15:0] pc, input logic [10:0] offset,
                                            input logic [15:0] first_val,
                                            input logic [15:0] second_val,
                                            input logic [15:0] imm_val);
    instr_word_t w;
    w.mode       = mode;
    w.use_imm    = use_imm;
    w.pc         = pc;
    w.offset     = offset;
    w.first_val  = first_val;
    w.second_val = second_val;
    w.imm_val    = imm_val;
    return w;
  endfunction

  // Operand values leaning toward the corners
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // aligned: pc, offset and register target even, so every target is legal
  function automatic instr_word_t random_word(input logic [2:0] mode, input bit aligned);
    instr_word_t w;
    w.mode       = mode;
    w.use_imm    = 1'($urandom_range(0, 1));
    w.pc         = pick_value();
    w.offset     = 11'($urandom);
    w.first_val  = pick_value();
    w.second_val = pick_value();
    w.imm_val    = pick_value();
    if (aligned) begin
      w.pc[0]         = 1'b0;
      w.offset[0]     = 1'b0;
      w.second_val[0] = 1'b0;
    end
    return w;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 15;
      default: return 35;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      error_count++;
      $display("%0t ns: result %0d %s expected %h actual %h",
               $time, results_seen, name, exp_val, act_val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the head of the queue, holds it until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      send_cycle++;
      if (send_cycle % 97 == 0) send_idle_pct = pick_idle_pct();
      if (!(s_axis_tvalid_i && !word_taken)) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_instrs.size() >= TailWords && hold_cycles == 0 &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 10);
        end
        if (send_gap == 0 && pending_instrs.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= {pending_instrs[0].use_imm, pending_instrs[0].mode};
          s_axis_tdata_i  <= {5'b0, pending_instrs[0].imm_val, pending_instrs[0].second_val,
                              pending_instrs[0].first_val, pending_instrs[0].offset,
                              pending_instrs[0].pc};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts plus one long hold-off so the unit backs up
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      recv_cycle++;
      if (recv_cycle % 89 == 0) recv_idle_pct = pick_idle_pct();
      if (hold_cycles > 0) begin
        hold_cycles--;
      end else if (!hold_done && instrs_accepted >= HoldAfter) begin
        hold_done   = 1'b1;
        hold_cycles = HoldCycles;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else if (pending_instrs.size() >= TailWords &&
                   $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(1, 10);
      end
      m_axis_tready_i <= (hold_cycles == 0 && recv_gap == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the result word first, then predict the accepted input word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      got = exec_result_t'(m_axis_tdata_o);
      if (predicted_results.size() == 0) begin
        error_count++;
        $display("%0t ns: result %h arrived with nothing expected", $time, m_axis_tdata_o);
      end else begin
        want = predicted_results.pop_front();
        check_field("next_pc", want.next_pc, got.next_pc);
        check_field("pc_written", 16'(want.pc_written), 16'(got.pc_written));
        check_field("fault_code", 16'(want.fault), 16'(got.fault));
        check_field("fault_address", want.fault_addr, got.fault_addr);
        check_field("halted", 16'(want.halted), 16'(got.halted));
        check_field("zero_flag", 16'(want.zero), 16'(got.zero));
        check_field("negative_flag", 16'(want.negative), 16'(got.negative));
        check_field("carry_flag", 16'(want.carry), 16'(got.carry));
        check_field("overflow_flag", 16'(want.overflow), 16'(got.overflow));
      end
    end

    word_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (word_taken) begin
      instrs_accepted++;
      predicted = execute_instr(pending_instrs.pop_front());
      predicted_results.push_back(predicted);
      if (predicted.pc_written) redirect_count++;
      if (predicted.halted) halt_count++;
      fault_tally[predicted.fault]++;
    end
    if (s_axis_tvalid_i && !s_axis_tready_o) input_stall_cycles++;
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    instr_word_t w;
    int          depth;

    // Directed opener
    pending_instrs.push_back(make_word(OP_RET, 1'b0, 16'h0010, '0, '0, '0, '0)); // empty
    pending_instrs.push_back(make_word(OP_CMP, 1'b1, '0, '0, 16'h1234, '0, 16'h1234));
    pending_instrs.push_back(make_word(OP_JZ, 1'b1, 16'h0100, 11'h400, '0, '0, '0));
    pending_instrs.push_back(make_word(OP_JNZ, 1'b0, 16'h0102, '0, '0, 16'h0200, '0));
    pending_instrs.push_back(make_word(OP_CMP, 1'b0, '0, '0, 16'h0000, 16'h0001, '0));
    pending_instrs.push_back(make_word(OP_CMP, 1'b1, '0, '0, 16'h8000, '0, 16'h0001));
    pending_instrs.push_back(make_word(OP_CMP, 1'b1, '0, '0, 16'h7FFF, '0, 16'hFFFF));
    pending_instrs.push_back(make_word(OP_JNZ, 1'b0, 16'h0300, '0, '0, 16'hFFFE, '0));
    pending_instrs.push_back(make_word(OP_JZ, 1'b0, 16'h0302, '0, '0, 16'h0400, '0));
    pending_instrs.push_back(make_word(OP_JMP, 1'b0, 16'h0304, '0, '0, 16'hFFFF, '0));
    pending_instrs.push_back(make_word(OP_JMP, 1'b0, 16'h0306, '0, '0, 16'h0001, '0));
    pending_instrs.push_back(make_word(OP_JMP, 1'b1, 16'hFFFE, 11'h002, '0, '0, '0)); // wraps
    pending_instrs.push_back(make_word(OP_JMP, 1'b1, 16'h1000, 11'h3FE, '0, '0, '0));
    pending_instrs.push_back(make_word(OP_JMP, 1'b1, 16'h1000, 11'h3FF, '0, '0, '0));
    pending_instrs.push_back(make_word(OP_CALL, 1'b1, 16'h2000, 11'h010, '0, '0, '0));
    pending_instrs.push_back(make_word(OP_CALL, 1'b0, 16'h2012, '0, '0, 16'h3001, '0));
    pending_instrs.push_back(make_word(OP_CALL, 1'b0, 16'h2014, '0, '0, 16'hFFFF, '0));
    pending_instrs.push_back(make_word(OP_CALL, 1'b0, 16'h1235, '0, '0, 16'h4000, '0));
    pending_instrs.push_back(make_word(OP_RET, 1'b0, 16'h4002, '0, '0, '0, '0)); // odd pop
    pending_instrs.push_back(make_word(OP_RET, 1'b0, 16'h4004, '0, '0, '0, '0));
    pending_instrs.push_back(make_word(OP_CALL, 1'b0, 16'hFFFF, '0, '0, 16'h0000, '0));
    pending_instrs.push_back(make_word(OP_RET, 1'b0, 16'h0002, '0, '0, '0, '0)); // bounds
    pending_instrs.push_back(make_word(OP_NOP, 1'b1, 16'h5555, 11'h2AA, '1, '1, '1));
    pending_instrs.push_back(make_word(ModeReserved, 1'b0, 16'hAAAA, 11'h555, '0, '0, '0));
    pending_instrs.push_back(make_word(OP_CMP, 1'b0, '0, '0, 16'hFFFF, 16'hFFFF, 16'h0001));
    pending_instrs.push_back(make_word(OP_RET, 1'b1, 16'h0020, '0, '0, '0, '0)); // empty

    // Fill the return stack past full, then drain it past empty
    repeat (StackWords + 4) pending_instrs.push_back(random_word(OP_CALL, 1'b1));
    repeat (StackWords + 4) pending_instrs.push_back(random_word(OP_RET, 1'b0));

    // Random part, mostly well-formed sequences
    while (pending_instrs.size() < TotalWords) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // compare, often equal, then a conditional jump on its result
          w = random_word(OP_CMP, 1'b0);
          if ($urandom_range(0, 1)) begin
            if (w.use_imm) w.imm_val = w.first_val;
            else w.second_val = w.first_val;
          end
          pending_instrs.push_back(w);
          pending_instrs.push_back(random_word($urandom_range(0, 1) ? OP_JZ : OP_JNZ,
                                               $urandom_range(0, 3) != 0));
        end
        4, 5, 6: begin
          depth = $urandom_range(1, 6);
          repeat (depth) pending_instrs.push_back(random_word(OP_CALL,
                                                              $urandom_range(0, 4) != 0));
          repeat (depth) pending_instrs.push_back(random_word(OP_RET, 1'b0));
        end
        default: begin
          pending_instrs.push_back(random_word(3'($urandom_range(0, 7)),
                                               1'($urandom_range(0, 1))));
        end
      endcase
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_instrs.size() != 0 || predicted_results.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d instructions: %0d pc redirects, %0d halts, faults %0d/%0d/%0d",
             instrs_accepted, redirect_count, halt_count, fault_tally[FAULT_BOUNDS],
             fault_tally[FAULT_ALIGN], fault_tally[FAULT_STACK]);
    $display("Input was back-pressured for %0d cycles; %0d results checked, %0d errors",
             input_stall_cycles, results_seen, error_count);
    if (error_count == 0) begin
      $display("compare_and_control_flow_unit_core verification clean");
    end else begin
      $display("compare_and_control_flow_unit_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutNs);
    $display("Timed out with %0d words queued and %0d results outstanding",
             pending_instrs.size(), predicted_results.size());
    $display("compare_and_control_flow_unit_core verification failed");
    $finish;
  end

endmodule
